FILE: rtl/core/uepd_pkg.sv
// Shared types and constants for the ultrasonic echo presence detector.
// Used by uepd_eval and ultrasonic_echo_presence_detector; depends on nothing.

package uepd_pkg;

   // Timer stamp width; the pulse width wraps modulo 2^TimerBits
   localparam int TimerBits = 16;
   localparam int CaptureBits = 16;

   // Register widths
   localparam int DistBits = 14;
   localparam int LimitBits = 4;
   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits = 14;

   // Register indexes
   localparam logic [CsrIndexBits-1:0] CsrNearThreshold = 2'd0;
   localparam logic [CsrIndexBits-1:0] CsrFarThreshold = 2'd1;
   localparam logic [CsrIndexBits-1:0] CsrConfirmLimit = 2'd2;

   // Register reset values
   localparam logic [DistBits-1:0] NearReset = 14'd150;
   localparam logic [DistBits-1:0] FarReset = 14'd200;
   localparam logic [LimitBits-1:0] LimitReset = 4'd3;

   // Request commands
   localparam logic CmdStart = 1'b0;
   localparam logic CmdCapture = 1'b1;

   // mm = width * 1715 / 10000 = width * 343 / 2000, done as a multiply by a
   // rounded-up reciprocal and a shift. With 2^MmShift > 2000 * 2^TimerBits
   // the rounding error stays below 1/2000 and the floor is exact.
   localparam int MmShift = TimerBits + 11;
   localparam longint unsigned MmRecip =
      ((64'd343 << MmShift) + 64'd1999) / 64'd2000;
   localparam int RecipBits = $clog2(MmRecip + 1);
   localparam int ProdBits = TimerBits + RecipBits;
   localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

   typedef struct packed {
      logic [DistBits-1:0]  near_threshold_mm;
      logic [DistBits-1:0]  far_threshold_mm;
      logic [LimitBits-1:0] confirm_limit;
   } cfg_type;

   typedef struct packed {
      logic                 waiting_fall;
      logic [TimerBits-1:0] rise_time;
      logic [LimitBits-1:0] detect_run;
      logic [LimitBits-1:0] release_run;
      logic                 present;
   } state_type;

   typedef struct packed {
      logic                measurement_done;
      logic [DistBits-1:0] distance_mm;
      logic                present;
   } result_type;

endpackage

FILE: rtl/core/ultrasonic_echo_presence_detector.sv
// Top level of the ultrasonic echo presence detector: request register,
// result register, register file. Depends on uepd_pkg and uepd_eval.
//
//   channel  dir  handshake              payload
//   req_     in   req_valid / req_stall  req_cmd, req_capture_time
//   rsp_     out  rsp_valid / rsp_stall  rsp_measurement_done, rsp_distance_mm,
//                                        rsp_present
//   csr_     in   csr_write              csr_index, csr_data
//
// One request per cycle while req_stall is low; an accepted request passes through the
// request register, then one multiply-and-compare pass into the result register.
// Tracking state is updated as a request moves into the result register.
// Reset is synchronous and clears control state and the register file to defaults.
// req_stall rises only when the request register is full and the result
// register is held by rsp_stall.

module ultrasonic_echo_presence_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [uepd_pkg::CaptureBits-1:0]     req_capture_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_measurement_done,
   output logic [uepd_pkg::DistBits-1:0]        rsp_distance_mm,
   output logic                                 rsp_present,
   input  logic                                 csr_write,
   input  logic [uepd_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [uepd_pkg::CsrDataBits-1:0]     csr_data
);

   uepd_pkg::cfg_type                 cfg_ff, cfg_in;
   uepd_pkg::state_type               st_ff, st_in;
   uepd_pkg::state_type               st_eval;
   uepd_pkg::result_type              res_ff, res_eval;
   logic                              a_valid_ff, a_valid_in;
   logic                              a_cmd_ff;
   logic [uepd_pkg::CaptureBits-1:0]  a_cap_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              out_blocked;
   logic                              advance;
   logic                              accept;

   // Handshake
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign advance     = a_valid_ff && !out_blocked;
   assign req_stall   = a_valid_ff && out_blocked;
   assign accept      = req_valid && !req_stall;

   assign a_valid_in   = accept ? 1'b1 : (advance ? 1'b0 : a_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : out_blocked;
   assign st_in        = advance ? st_eval : st_ff;

   // Register file writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            uepd_pkg::CsrNearThreshold:
               cfg_in.near_threshold_mm = uepd_pkg::DistBits'(csr_data);
            uepd_pkg::CsrFarThreshold:
               cfg_in.far_threshold_mm = uepd_pkg::DistBits'(csr_data);
            uepd_pkg::CsrConfirmLimit:
               cfg_in.confirm_limit = uepd_pkg::LimitBits'(csr_data);
            default: ;
         endcase
      end
   end

   uepd_eval u_eval (
      .cfg          (cfg_ff),
      .st_cur       (st_ff),
      .cmd          (a_cmd_ff),
      .capture_time (a_cap_ff),
      .st_nxt       (st_eval),
      .result       (res_eval)
   );

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff <= '0;
         cfg_ff.near_threshold_mm <= uepd_pkg::NearReset;
         cfg_ff.far_threshold_mm <= uepd_pkg::FarReset;
         cfg_ff.confirm_limit <= uepd_pkg::LimitReset;
      end else begin
         a_valid_ff <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff <= st_in;
         cfg_ff <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         a_cmd_ff <= req_cmd;
         a_cap_ff <= req_capture_time;
      end
      if (advance) begin
         res_ff <= res_eval;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_measurement_done = res_ff.measurement_done;
   assign rsp_distance_mm      = res_ff.distance_mm;
   assign rsp_present          = res_ff.present;

   // Checks
   a_runs_exclusive: assert property (@(posedge clock) disable iff (reset)
      !((st_ff.detect_run != '0) && (st_ff.release_run != '0)))
      else $error("detect and release runs both nonzero");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !a_valid_ff |-> !req_stall)
      else $error("stall raised with empty request register");

   a_present_needs_measure: assert property (@(posedge clock) disable iff (reset)
      (advance && (st_eval.present != st_ff.present)) |-> res_eval.measurement_done)
      else $error("presence changed without a finished measurement");

   a_result_present_tracks: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_present == st_ff.present))
      else $error("result presence differs from tracked state");

endmodule

FILE: rtl/core/uepd_eval.sv
// Per-request evaluation: echo width, distance conversion, hysteresis runs.
// Pure combinational; types and constants come from uepd_pkg.

module uepd_eval (
   input  uepd_pkg::cfg_type                  cfg,
   input  uepd_pkg::state_type                st_cur,
   input  logic                               cmd,
   input  logic [uepd_pkg::CaptureBits-1:0]   capture_time,
   output uepd_pkg::state_type                st_nxt,
   output uepd_pkg::result_type               result
);

   logic [uepd_pkg::TimerBits-1:0]  cap_t;
   logic [uepd_pkg::TimerBits-1:0]  pulse_width;
   logic [uepd_pkg::ProdBits-1:0]   prod;
   logic [uepd_pkg::ProdBits-1:0]   dist_wide;
   logic [uepd_pkg::DistBits-1:0]   dist_mm;
   logic [uepd_pkg::LimitBits:0]    det_inc;
   logic [uepd_pkg::LimitBits:0]    rel_inc;
   logic                            det_reached;
   logic                            rel_reached;
   logic [uepd_pkg::LimitBits-1:0]  det_bumped;
   logic [uepd_pkg::LimitBits-1:0]  rel_bumped;

   // Width modulo timer range, then scale to millimeters
   assign cap_t       = uepd_pkg::TimerBits'(capture_time);
   assign pulse_width = cap_t - st_cur.rise_time;
   assign prod        = uepd_pkg::ProdBits'(pulse_width)
                      * uepd_pkg::ProdBits'(uepd_pkg::MmRecip);
   assign dist_wide   = prod >> uepd_pkg::MmShift;
   assign dist_mm     = (dist_wide > uepd_pkg::ProdBits'(uepd_pkg::DistMax)) ?
                        uepd_pkg::DistMax : dist_wide[uepd_pkg::DistBits-1:0];

   // Run counters: increment, clamp at the confirm limit
   assign det_inc     = {1'b0, st_cur.detect_run} + 1'b1;
   assign rel_inc     = {1'b0, st_cur.release_run} + 1'b1;
   assign det_reached = det_inc >= {1'b0, cfg.confirm_limit};
   assign rel_reached = rel_inc >= {1'b0, cfg.confirm_limit};
   assign det_bumped  = det_reached ? cfg.confirm_limit
                                    : det_inc[uepd_pkg::LimitBits-1:0];
   assign rel_bumped  = rel_reached ? cfg.confirm_limit
                                    : rel_inc[uepd_pkg::LimitBits-1:0];

   always_comb begin
      st_nxt = st_cur;
      result.measurement_done = 1'b0;
      result.distance_mm = '0;
      if (cmd == uepd_pkg::CmdStart) begin
         st_nxt.waiting_fall = 1'b0;
         st_nxt.rise_time = '0;
      end else if (!st_cur.waiting_fall) begin
         // rising edge: remember stamp
         st_nxt.waiting_fall = 1'b1;
         st_nxt.rise_time = cap_t;
      end else begin
         // falling edge: finished measurement, classify it
         st_nxt.waiting_fall = 1'b0;
         result.measurement_done = 1'b1;
         result.distance_mm = dist_mm;
         if (dist_mm <= cfg.near_threshold_mm) begin
            st_nxt.detect_run = det_bumped;
            st_nxt.release_run = '0;
            if (det_reached) begin
               st_nxt.present = 1'b1;
            end
         end else if (dist_mm >= cfg.far_threshold_mm) begin
            st_nxt.release_run = rel_bumped;
            st_nxt.detect_run = '0;
            if (rel_reached) begin
               st_nxt.present = 1'b0;
            end
         end else begin
            st_nxt.detect_run = '0;
            st_nxt.release_run = '0;
         end
      end
      result.present = st_nxt.present;
   end

endmodule
